// ===== design/ifd_pkg.sv =====
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and constants of the imu frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ifd_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'h59;
	localparam logic [7:0] HDR_SECOND = 8'h53;

	typedef enum logic [2:0] {
		PH_HUNT1   = 3'd0,
		PH_HUNT2   = 3'd1,
		PH_NUM_LO  = 3'd2,
		PH_NUM_HI  = 3'd3,
		PH_LEN     = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_CK_A    = 3'd6,
		PH_CK_B    = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_ACCEPT  = 2'd1,
		KIND_REJECT  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [15:0] frame_number;
		logic        frame_gap;
		logic [7:0]  payload_length;
	} result_t;

endpackage

`default_nettype wire

// ===== design/imu_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// imu_frame_deframer
// Serial frame deframer with an 8-bit Fletcher checksum pair.
// ----------------------------------------------------------------------------
// Takes one received byte per transfer and accepts a new byte every clock
// cycle while in_stall is low; each byte is held in the input register,
// is parsed by the frame state machine and, if it produces a result, is
// registered in the result register, whose valid flag is out_valid.
// Frames are 0x59 0x53, frame number low then high, length, payload, and
// two checksum bytes. Payload bytes come out as kind 0, the frame ends with
// kind 1 (accepted) or kind 2 (rejected); a zero-length frame gives nothing.
// in_stall rises only while the result register is full and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       result_kind,
	output logic [7:0]       payload_byte,
	output logic [15:0]      frame_number,
	output logic             frame_gap,
	output logic [7:0]       payload_length
);

	import ifd_pkg::*;

	logic       valid_s1, advance, res_valid;
	logic [7:0] byte_s1;
	result_t    res, res_s2;

	ifd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	ifd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ifd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_s2    (res_s2)
	);

	assign result_kind    = 2'(res_s2.kind);
	assign payload_byte   = res_s2.payload_byte;
	assign frame_number   = res_s2.frame_number;
	assign frame_gap      = res_s2.frame_gap;
	assign payload_length = res_s2.payload_length;

	// input side waits only on a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result");

	a_end_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_kind != 2'(KIND_PAYLOAD))) |-> (payload_byte == 8'd0))
		else $error("frame end carries a payload byte");

	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_kind == 2'(KIND_PAYLOAD))) |-> (payload_length != 8'd0))
		else $error("payload byte from a zero-length frame");

	a_no_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

endmodule

`default_nettype wire

// ===== design/ifd_in_reg.sv =====
// ----------------------------------------------------------------------------
// ifd_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ifd_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	logic accept;

	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ===== design/ifd_parser.sv =====
// ----------------------------------------------------------------------------
// ifd_parser
// Frame state machine with header hunt, running checksum pair and gap check.
// ----------------------------------------------------------------------------
`default_nettype none

module ifd_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  wire logic [7:0]     byte_s1,
	output logic                res_valid,
	output ifd_pkg::result_t    res
);

	import ifd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  sum_a_q, sum_b_q, left_q, len_q;
	logic [15:0] number_q, prev_q;
	logic        gap_q;
	logic [7:0]  sum_a_add, sum_b_add, left_dec;
	logic [15:0] number_full;
	logic        gap_new;

	assign sum_a_add   = sum_a_q + byte_s1;
	assign sum_b_add   = sum_b_q + sum_a_add;
	assign left_dec    = left_q - 8'd1;
	assign number_full = {byte_s1, number_q[7:0]};
	assign gap_new     = (prev_q != 16'd0) &&
		({1'b0, number_full} > ({1'b0, prev_q} + 17'd1));

	// next state
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT1:   if (byte_s1 == HDR_FIRST) phase_d = PH_HUNT2;
			PH_HUNT2:   phase_d = (byte_s1 == HDR_SECOND) ? PH_NUM_LO : PH_HUNT1;
			PH_NUM_LO:  phase_d = PH_NUM_HI;
			PH_NUM_HI:  phase_d = PH_LEN;
			PH_LEN:     phase_d = (byte_s1 == 8'd0) ? PH_HUNT1 : PH_PAYLOAD;
			PH_PAYLOAD: if (left_dec == 8'd0) phase_d = PH_CK_A;
			PH_CK_A:    phase_d = (byte_s1 == sum_a_q) ? PH_CK_B : PH_HUNT1;
			PH_CK_B:    phase_d = PH_HUNT1;
			default:    phase_d = PH_HUNT1;
		endcase
	end

	// outputs
	always_comb begin
		res_valid          = 1'b0;
		res.kind           = KIND_PAYLOAD;
		res.payload_byte   = 8'd0;
		res.frame_number   = number_q;
		res.frame_gap      = gap_q;
		res.payload_length = len_q;
		unique case (phase_q)
			PH_PAYLOAD: begin
				res_valid        = 1'b1;
				res.payload_byte = byte_s1;
			end
			PH_CK_A: begin
				res_valid = (byte_s1 != sum_a_q);
				res.kind  = KIND_REJECT;
			end
			PH_CK_B: begin
				res_valid = 1'b1;
				res.kind  = (byte_s1 == sum_b_q) ? KIND_ACCEPT : KIND_REJECT;
			end
			default: res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT1;
			sum_a_q  <= 8'd0;
			sum_b_q  <= 8'd0;
			left_q   <= 8'd0;
			len_q    <= 8'd0;
			number_q <= 16'd0;
			prev_q   <= 16'd0;
			gap_q    <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			unique case (phase_q)
				PH_HUNT1: begin
				end
				PH_HUNT2: begin
					sum_a_q <= 8'd0;
					sum_b_q <= 8'd0;
				end
				PH_NUM_LO: begin
					sum_a_q  <= sum_a_add;
					sum_b_q  <= sum_b_add;
					number_q <= {8'd0, byte_s1};
				end
				PH_NUM_HI: begin
					sum_a_q  <= sum_a_add;
					sum_b_q  <= sum_b_add;
					number_q <= number_full;
					prev_q   <= number_full;
					gap_q    <= gap_new;
				end
				PH_LEN: begin
					len_q <= byte_s1;
					if (byte_s1 == 8'd0) begin
						sum_a_q <= 8'd0;
						sum_b_q <= 8'd0;
						left_q  <= 8'd0;
					end else begin
						sum_a_q <= sum_a_add;
						sum_b_q <= sum_b_add;
						left_q  <= byte_s1;
					end
				end
				PH_PAYLOAD: begin
					sum_a_q <= sum_a_add;
					sum_b_q <= sum_b_add;
					left_q  <= left_dec;
				end
				PH_CK_A: begin
					if (byte_s1 != sum_a_q) begin
						sum_a_q <= 8'd0;
						sum_b_q <= 8'd0;
						left_q  <= 8'd0;
					end
				end
				PH_CK_B: begin
					sum_a_q <= 8'd0;
					sum_b_q <= 8'd0;
					left_q  <= 8'd0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/ifd_out_reg.sv =====
// ----------------------------------------------------------------------------
// ifd_out_reg
// Result register: holds one result until the receiving side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ifd_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire logic              res_valid,
	input  wire ifd_pkg::result_t  res,
	output logic                   advance,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output ifd_pkg::result_t       res_s2
);

	import ifd_pkg::*;

	logic load;

	assign advance = valid_s1 && (!out_valid || !out_stall);
	assign load    = advance && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire
